// ===== hw/rtl/dctd_pkg.sv =====
// ----------------------------------------------------------------------------
// Dependency task dispatcher package
// Field widths, request and result codes, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dctd_pkg;

  // Payload field widths
  localparam int MODE_W = 2;
  localparam int IDX_W  = 5;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 6;

  // Default sizing of the graph
  localparam int MAX_TASKS_DEF = 32;
  localparam int MAX_DEPS_DEF  = 16;

  // Saturation limit of the pending and done counters
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DONE  = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DISPATCH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMPLETED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FAILED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EDGE_OK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EDGE_REJ  = 3'd4;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_TASK_COUNT = '0;
  localparam logic [CNT_W-1:0] TASK_COUNT_RST = 6'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;        // capture the request fields
    logic clear_all;    // empty the graph and the frame state
    logic edge_sel;     // memories addressed for an edge request
    logic edge_commit;  // apply the edge and post its result
    logic start_init;   // reset the frame and the scan index
    logic cpl_update;   // pending, failed and done updates of a completion
    logic step_start;   // one index of the start scan
    logic step_cpl;     // one index of the completion scan
    logic finish;       // post the closing result of the request
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic t_in_range;
    logic ok;
    logic failed;
    logic scan_done;
    logic out_free;
    logic hold_valid;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dependency_counting_task_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// Dependency counting task dispatcher
// Tracks a task graph by task index and dispatches tasks whose dependencies
// have all completed.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds in_stall high until that
// request has been worked through. A start frame and a successful completion
// each walk the task slots in use (task_count, limited to MAX_TASKS), one slot
// per clock while the result register is free, through the remaining-count
// memory; a failed completion or one received after a failure skips the walk,
// and a completion for a slot outside the range in use ends without a result.
// Graph state after reset and after a clear is tracked with per-entry valid
// bits, so there is no clearing pass.
`default_nettype none

module dependency_counting_task_dispatcher_unit
  import dctd_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int MAX_DEPS  = MAX_DEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [IDX_W-1:0]      task_index,
  input  wire logic [IDX_W-1:0]      dependency_index,
  input  wire logic                  success,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [KIND_W-1:0]     kind,
  output logic      [IDX_W-1:0]      ready_task,
  output logic      [CNT_W-1:0]      tasks_done,
  output logic                       last,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [CNT_W-1:0] task_count;
  logic             reg_hit;
  cmd_t             cmd;
  sts_t             sts;

  // The only register is the number of task slots in use. The user must write it
  // while the block is idle, which the block itself does not enforce; the datapath reads it directly.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_TASK_COUNT);
  assign prdata  = reg_hit ? APB_DATA_W'(task_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= TASK_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      task_count <= pwdata[CNT_W-1:0];
    end
  end

  // The controller steps through each request; the datapath holds the graph,
  // the frame counters and the result register.
  dctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  dctd_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_DEPS  (MAX_DEPS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .task_index       (task_index),
    .dependency_index (dependency_index),
    .success          (success),
    .task_count       (task_count),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .kind             (kind),
    .ready_task       (ready_task),
    .tasks_done       (tasks_done),
    .last             (last)
  );

  // Only one request is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another was still in progress");

  // A held dispatch exists only while a request is being worked on.
  assert property (@(posedge clk) disable iff (rst)
    sts.hold_valid |-> in_stall)
    else $error("dispatch left in the hold stage after the request ended");

  // Edge results are always the single and final result of their request.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EDGE_OK || kind == KIND_EDGE_REJ) |-> last)
    else $error("edge result without the last flag");

  // Only dispatch results name a task.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DISPATCH |-> ready_task == '0)
    else $error("non-dispatch result carries a task index");

endmodule

`default_nettype wire

// ===== hw/rtl/dctd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dctd_datapath.sv =====
// ----------------------------------------------------------------------------
// Dependency task dispatcher datapath
// Graph memories, frame counters, the scan index, a one-entry hold stage for
// dispatches and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dctd_datapath
  import dctd_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int MAX_DEPS  = MAX_DEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [IDX_W-1:0]  task_index,
  input  wire logic [IDX_W-1:0]  dependency_index,
  input  wire logic              success,
  input  wire logic [CNT_W-1:0]  task_count,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic      [KIND_W-1:0] kind,
  output logic      [IDX_W-1:0]  ready_task,
  output logic      [CNT_W-1:0]  tasks_done,
  output logic                   last
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int NW = $clog2(MAX_TASKS + 1);
  localparam int CW = (NW > CNT_W) ? NW : CNT_W;
  localparam int DW = $clog2(MAX_DEPS + 1);

  logic [IDX_W-1:0]     t_reg;
  logic [IDX_W-1:0]     d_reg;
  logic                 ok_reg;
  logic [NW-1:0]        idx;
  logic [NW-1:0]        idx_next;
  logic [CNT_W-1:0]     pending;
  logic [CNT_W-1:0]     done_cnt;
  logic                 failed;
  logic [MAX_TASKS-1:0] sched;
  logic [MAX_TASKS-1:0] dc_vld;
  logic [MAX_TASKS-1:0] mask_vld;
  logic [MAX_TASKS-1:0] rem_vld;
  logic                 hold_v;
  logic [TW-1:0]        hold_task;

  logic [NW-1:0]        n;
  logic [TW-1:0]        t_idx;
  logic [TW-1:0]        d_idx;
  logic [TW-1:0]        cur;
  logic                 t_ok;
  logic                 d_ok;
  logic                 accept;

  logic [DW-1:0]        dc_rdata;
  logic [DW-1:0]        dc_eff;
  logic [TW-1:0]        dc_raddr;
  logic                 dc_vld_sel;
  logic [MAX_TASKS-1:0] mask_rdata;
  logic [MAX_TASKS-1:0] mask_eff;
  logic [TW-1:0]        mask_raddr;
  logic [DW-1:0]        rem_rdata;
  logic [DW-1:0]        rem_eff;
  logic [DW-1:0]        rem_dec;
  logic                 rem_we;
  logic [DW-1:0]        rem_wdata;

  logic                 dep_bit;
  logic                 disp_start;
  logic                 disp_cpl;
  logic                 dispatch;

  logic                 out_load;
  logic [KIND_W-1:0]    kind_next;
  logic [IDX_W-1:0]     ready_task_next;
  logic                 last_next;

  // Slots in use, limited to the storage size.
  assign n = (CW'(task_count) > CW'(MAX_TASKS)) ? NW'(MAX_TASKS) : NW'(task_count);

  assign t_idx = TW'(t_reg);
  assign d_idx = TW'(d_reg);
  assign cur   = idx[TW-1:0];
  assign t_ok  = CW'(t_reg) < CW'(n);
  assign d_ok  = CW'(d_reg) < CW'(n);

  always_comb begin
    if (cmd.start_init || cmd.cpl_update) begin
      idx_next = '0;
    end else if (cmd.step_start || cmd.step_cpl) begin
      idx_next = idx + NW'(1);
    end else begin
      idx_next = idx;
    end
  end

  // Dependency counts: edges address the waiting task, the start scan walks the index.
  assign dc_raddr   = cmd.edge_sel ? t_idx : idx_next[TW-1:0];
  assign dc_vld_sel = cmd.edge_sel ? dc_vld[t_idx] : dc_vld[cur];
  assign dc_eff     = dc_vld_sel ? dc_rdata : '0;

  // Dependent masks: edges read the prerequisite's row, completions the finished task's row.
  assign mask_raddr = cmd.edge_sel ? d_idx : t_idx;
  assign mask_eff   = (cmd.edge_sel ? mask_vld[d_idx] : mask_vld[t_idx]) ? mask_rdata : '0;

  assign rem_eff = rem_vld[cur] ? rem_rdata : '0;
  assign rem_dec = (rem_eff == '0) ? '0 : rem_eff - DW'(1);

  assign accept = t_ok && d_ok && (t_reg != d_reg) && !mask_eff[t_idx]
                  && (dc_eff < DW'(MAX_DEPS));

  assign dep_bit    = mask_eff[cur];
  assign disp_start = (dc_eff == '0);
  assign disp_cpl   = dep_bit && (rem_dec == '0) && !sched[cur];
  assign dispatch   = (cmd.step_start && disp_start) || (cmd.step_cpl && disp_cpl);

  assign rem_we    = cmd.step_start || (cmd.step_cpl && dep_bit);
  assign rem_wdata = cmd.step_start ? dc_eff : rem_dec;

  dctd_ram #(.WIDTH(DW), .DEPTH(MAX_TASKS)) u_dep_count_ram (
    .clk   (clk),
    .we    (cmd.edge_commit && accept),
    .waddr (t_idx),
    .wdata (dc_eff + DW'(1)),
    .raddr (dc_raddr),
    .rdata (dc_rdata)
  );

  dctd_ram #(.WIDTH(MAX_TASKS), .DEPTH(MAX_TASKS)) u_dep_mask_ram (
    .clk   (clk),
    .we    (cmd.edge_commit && accept),
    .waddr (d_idx),
    .wdata (mask_eff | (MAX_TASKS'(1) << t_idx)),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  dctd_ram #(.WIDTH(DW), .DEPTH(MAX_TASKS)) u_remaining_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (cur),
    .wdata (rem_wdata),
    .raddr (idx_next[TW-1:0]),
    .rdata (rem_rdata)
  );

  // Result selection. A dispatch is held back one step so that the final one can
  // carry the last flag.
  always_comb begin
    out_load        = 1'b0;
    kind_next       = KIND_DISPATCH;
    ready_task_next = IDX_W'(hold_task);
    last_next       = 1'b0;
    if (cmd.edge_commit) begin
      out_load        = 1'b1;
      kind_next       = accept ? KIND_EDGE_OK : KIND_EDGE_REJ;
      ready_task_next = '0;
      last_next       = 1'b1;
    end else if (dispatch && hold_v) begin
      out_load = 1'b1;
    end else if (cmd.finish) begin
      if (hold_v) begin
        out_load  = 1'b1;
        last_next = 1'b1;
      end else if (pending == '0) begin
        out_load        = 1'b1;
        kind_next       = failed ? KIND_FAILED : KIND_COMPLETED;
        ready_task_next = '0;
        last_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      pending   <= '0;
      done_cnt  <= '0;
      failed    <= 1'b0;
      sched     <= '0;
      dc_vld    <= '0;
      mask_vld  <= '0;
      rem_vld   <= '0;
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (cmd.clear_all) begin
        pending  <= '0;
        done_cnt <= '0;
        failed   <= 1'b0;
        sched    <= '0;
        dc_vld   <= '0;
        mask_vld <= '0;
        rem_vld  <= '0;
      end
      if (cmd.edge_commit && accept) begin
        dc_vld[t_idx]   <= 1'b1;
        mask_vld[d_idx] <= 1'b1;
      end
      if (cmd.start_init) begin
        pending  <= '0;
        done_cnt <= '0;
        failed   <= 1'b0;
        sched    <= '0;
        rem_vld  <= '0;
      end
      if (cmd.cpl_update) begin
        if (pending != '0) begin
          pending <= pending - CNT_W'(1);
        end
        if (!ok_reg) begin
          failed <= 1'b1;
        end else if (!failed && (done_cnt != CNT_MAX)) begin
          done_cnt <= done_cnt + CNT_W'(1);
        end
      end
      if (rem_we) begin
        rem_vld[cur] <= 1'b1;
      end
      if (dispatch) begin
        sched[cur] <= 1'b1;
        if (pending != CNT_MAX) begin
          pending <= pending + CNT_W'(1);
        end
        hold_v <= 1'b1;
      end else if (cmd.finish) begin
        hold_v <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      t_reg  <= task_index;
      d_reg  <= dependency_index;
      ok_reg <= success;
    end
    if (dispatch) begin
      hold_task <= cur;
    end
    if (out_load) begin
      kind       <= kind_next;
      ready_task <= ready_task_next;
      tasks_done <= done_cnt;
      last       <= last_next;
    end
  end

  assign sts.t_in_range = t_ok;
  assign sts.ok         = ok_reg;
  assign sts.failed     = failed;
  assign sts.scan_done  = (idx == n);
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.hold_valid = hold_v;

endmodule

`default_nettype wire

// ===== hw/rtl/dctd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dependency task dispatcher controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dctd_ctrl
  import dctd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] mode,
  input  wire sts_t              sts,
  output cmd_t                   cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_CLEAR      = 4'd1;
  localparam logic [3:0] S_EDGE_RD    = 4'd2;
  localparam logic [3:0] S_EDGE_EV    = 4'd3;
  localparam logic [3:0] S_START      = 4'd4;
  localparam logic [3:0] S_START_SCAN = 4'd5;
  localparam logic [3:0] S_CPL        = 4'd6;
  localparam logic [3:0] S_CPL_SCAN   = 4'd7;
  localparam logic [3:0] S_END        = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (mode)
            MODE_CLEAR: state_next = S_CLEAR;
            MODE_EDGE:  state_next = S_EDGE_RD;
            MODE_START: state_next = S_START;
            default:    state_next = S_CPL;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear_all = 1'b1;
        state_next    = S_IDLE;
      end
      S_EDGE_RD: begin
        cmd.edge_sel = 1'b1;
        state_next   = S_EDGE_EV;
      end
      S_EDGE_EV: begin
        cmd.edge_sel = 1'b1;
        if (sts.out_free) begin
          cmd.edge_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_START: begin
        cmd.start_init = 1'b1;
        state_next     = S_START_SCAN;
      end
      S_START_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_END;
        end else if (sts.out_free) begin
          cmd.step_start = 1'b1;
        end
      end
      S_CPL: begin
        if (!sts.t_in_range) begin
          state_next = S_IDLE;
        end else begin
          cmd.cpl_update = 1'b1;
          state_next     = (sts.ok && !sts.failed) ? S_CPL_SCAN : S_END;
        end
      end
      S_CPL_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_END;
        end else if (sts.out_free) begin
          cmd.step_cpl = 1'b1;
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Dependency counting task dispatcher testbench
// Drives clear, edge, start and completion requests into the dispatcher with
// random gaps and result stalls, predicts every dispatch and frame report
// from a private copy of the task graph, and checks each result field.
// ----------------------------------------------------------------------------
module testbench
  import dctd_pkg::*;
;

  // Graph sizing used by the block under test (its parameter defaults).
  localparam int SLOTS     = MAX_TASKS_DEF;
  localparam int DEP_LIMIT = MAX_DEPS_DEF;

  // Idle cycles granted before a register write or the end of the run. A
  // request that yields no result may still be walking up to 32 slots.
  localparam int SETTLE_CYCLES  = 64;
  // Consecutive cycles without any handshake before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;
  // Rough number of requests in the whole run.
  localparam int TOTAL_REQS     = 110;

  localparam logic [APB_ADDR_W-1:0] TASK_COUNT_ADDR = {REG_TASK_COUNT, 2'b00};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  task_index;
    logic [IDX_W-1:0]  dependency_index;
    logic              success;
    logic              hold;  // present only once every expected result has come
  } task_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  ready_task;
    logic [CNT_W-1:0]  tasks_done;
    logic              last;
  } sched_event_t;

  // Clock and reset. Every input of the block starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     mode             = MODE_CLEAR;
  logic [IDX_W-1:0]      task_index       = '0;
  logic [IDX_W-1:0]      dependency_index = '0;
  logic                  success          = 1'b0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [KIND_W-1:0]     kind;
  logic [IDX_W-1:0]      ready_task;
  logic [CNT_W-1:0]      tasks_done;
  logic                  last;
  logic                  psel             = 1'b0;
  logic                  penable          = 1'b0;
  logic                  pwrite           = 1'b0;
  logic [APB_ADDR_W-1:0] paddr            = '0;
  logic [APB_DATA_W-1:0] pwdata           = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dependency_counting_task_dispatcher_unit dut (.*);

  // --------------------------------------------------------------------------
  // Predicted dispatcher state. It mirrors the graph (dependency totals and
  // the set of tasks waiting on each task) and the frame (remaining counts,
  // scheduled flags, open and finished counters, failure flag).
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] slots_cfg = TASK_COUNT_RST;
  bit   [4:0]       dep_total [SLOTS];
  bit   [SLOTS-1:0] waiters   [SLOTS];
  bit   [4:0]       left_deps [SLOTS];
  bit               queued    [SLOTS];
  int               open_tasks;
  logic [CNT_W-1:0] finished_tasks = '0;
  bit               frame_failed;

  sched_event_t due_events[$];   // results still owed by the block, oldest first
  sched_event_t step_events[$];  // results of the request being predicted

  task_req_t req_queue[$];       // requests not yet presented to the block
  task_req_t cur_req;
  int        reqs_queued;
  int        reqs_taken;
  int        mismatches;

  function automatic void reset_frame();
    for (int i = 0; i < SLOTS; i++) begin
      left_deps[i] = '0;
      queued[i]    = 1'b0;
    end
    open_tasks     = 0;
    finished_tasks = '0;
    frame_failed   = 1'b0;
  endfunction

  // Every result reports the finished count as it stands when it is posted.
  function automatic void add_event(input logic [KIND_W-1:0] k, input int t);
    sched_event_t ev;
    ev.kind       = k;
    ev.ready_task = t[IDX_W-1:0];
    ev.tasks_done = finished_tasks;
    ev.last       = 1'b0;
    step_events.insert(step_events.size(), ev);
  endfunction

  // Applies one accepted request to the predicted state and queues the
  // results it causes, with last set on the final one.
  function automatic void update_task_graph(input task_req_t r);
    int           n;
    bit           accept;
    sched_event_t ev;
    n = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
    case (r.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          dep_total[i] = '0;
          waiters[i]   = '0;
        end
        reset_frame();
      end
      MODE_EDGE: begin
        accept = r.task_index < n && r.dependency_index < n &&
                 r.task_index != r.dependency_index &&
                 !waiters[r.dependency_index][r.task_index] &&
                 dep_total[r.task_index] < DEP_LIMIT;
        if (accept) begin
          waiters[r.dependency_index][r.task_index] = 1'b1;
          dep_total[r.task_index]++;
        end
        add_event(accept ? KIND_EDGE_OK : KIND_EDGE_REJ, 0);
      end
      MODE_START: begin
        reset_frame();
        for (int i = 0; i < n; i++) begin
          left_deps[i] = dep_total[i];
          if (dep_total[i] == 0) begin
            queued[i] = 1'b1;
            open_tasks++;
            add_event(KIND_DISPATCH, i);
          end
        end
        // With no root at all the frame ends at once.
        if (open_tasks == 0) add_event(frame_failed ? KIND_FAILED : KIND_COMPLETED, 0);
      end
      default: begin
        // Completions of slots outside the active range are dropped silently.
        if (r.task_index < n) begin
          if (open_tasks > 0) open_tasks--;
          if (!r.success) begin
            frame_failed = 1'b1;
          end else if (!frame_failed) begin
            if (finished_tasks != CNT_MAX) finished_tasks++;
            for (int i = 0; i < n; i++) begin
              if (waiters[r.task_index][i]) begin
                if (left_deps[i] > 0) left_deps[i]--;
                if (left_deps[i] == 0 && !queued[i]) begin
                  queued[i] = 1'b1;
                  if (open_tasks < CNT_MAX) open_tasks++;
                  add_event(KIND_DISPATCH, i);
                end
              end
            end
          end
          if (open_tasks == 0) add_event(frame_failed ? KIND_FAILED : KIND_COMPLETED, 0);
        end
      end
    endcase
    foreach (step_events[i]) begin
      ev      = step_events[i];
      ev.last = (i == step_events.size() - 1);
      due_events.insert(due_events.size(), ev);
    end
    step_events.delete();
  endfunction

  // Idle lengths for both channels: mostly none or short, a few long ones.
  // During a calm stretch the channel does not idle at all.
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 9);
    if (calm || roll < 5) return 0;
    if (roll < 8) return $urandom_range(1, 3);
    if (roll < 9) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. A request that has been presented stays on the port until
  // the block takes it; the next one follows after a random gap. A request
  // marked hold waits until the block has delivered every expected result.
  // --------------------------------------------------------------------------
  int in_gap;
  int in_calm;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        update_task_graph(cur_req);
        reqs_taken++;
      end
      if (in_calm > 0) in_calm--;
      else if ($urandom_range(0, 99) == 0) in_calm = $urandom_range(40, 120);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0 &&
                     !(req_queue[0].hold && due_events.size() > 0)) begin
          cur_req          = req_queue.pop_front();
          in_valid         <= 1'b1;
          mode             <= cur_req.mode;
          task_index       <= cur_req.task_index;
          dependency_index <= cur_req.dependency_index;
          success          <= cur_req.success;
          in_gap           = pick_gap(in_calm > 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every accepted result is matched against the oldest
  // expectation; out_stall is raised at random to hold the result register.
  // --------------------------------------------------------------------------
  int           out_wait;
  int           out_calm;
  sched_event_t exp_ev;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0) begin
          $error("unexpected result: kind %0d ready_task %0d tasks_done %0d last %0d",
                 kind, ready_task, tasks_done, last);
          mismatches++;
        end else begin
          exp_ev = due_events.pop_front();
          if (kind !== exp_ev.kind) begin
            $error("kind: expected %0d, got %0d", exp_ev.kind, kind);
            mismatches++;
          end
          if (ready_task !== exp_ev.ready_task) begin
            $error("ready_task: expected %0d, got %0d", exp_ev.ready_task, ready_task);
            mismatches++;
          end
          if (tasks_done !== exp_ev.tasks_done) begin
            $error("tasks_done: expected %0d, got %0d", exp_ev.tasks_done, tasks_done);
            mismatches++;
          end
          if (last !== exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, last);
            mismatches++;
          end
        end
      end
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 99) == 0) out_calm = $urandom_range(40, 120);
      if (out_wait > 0) begin
        out_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_wait  = pick_gap(out_calm > 0);
      end
    end
  end

  // Watchdog: a long stretch with no request, result or register write means
  // the block has hung or owes a result it will never deliver.
  int quiet_cycles;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_req(input logic [MODE_W-1:0] m, input int t, input int d,
                          input int ok, input int hold);
    task_req_t r;
    r.mode             = m;
    r.task_index       = t[IDX_W-1:0];
    r.dependency_index = d[IDX_W-1:0];
    r.success          = ok[0];
    r.hold             = hold[0];
    req_queue.insert(req_queue.size(), r);
    reqs_queued++;
  endtask

  // Returns once every request has been taken and every result delivered,
  // plus enough cycles for a request without results to finish its scan.
  task automatic wait_idle();
    while (reqs_taken != reqs_queued || due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write through the configuration port, only while the block is idle.
  task automatic write_task_count(input int value);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TASK_COUNT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    slots_cfg = value[CNT_W-1:0];
  endtask

  // One frame: clear, a random acyclic graph (each edge points from a lower
  // to a higher index, so index order is a valid completion order), a start,
  // then the completions. A little noise mixes in stray edges, failures and
  // stray completions. With fan_in set, the last task collects edges from 20
  // predecessors so that the dependency limit is reached.
  task automatic build_frame(input int n, input bit fan_in);
    int t;
    int d;
    int edges;
    push_req(MODE_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
             $urandom_range(0, 1), 0);
    if (fan_in) begin
      for (d = 0; d < 20; d++) push_req(MODE_EDGE, n - 1, d, $urandom_range(0, 1), 0);
    end else if (n > 1) begin
      edges = $urandom_range(0, 2 * n);
      repeat (edges) begin
        if ($urandom_range(0, 7) == 0) begin
          push_req(MODE_EDGE, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 1), 0);
        end else begin
          t = $urandom_range(1, n - 1);
          d = $urandom_range(0, t - 1);
          push_req(MODE_EDGE, t, d, $urandom_range(0, 1), 0);
        end
      end
    end
    push_req(MODE_START, $urandom_range(0, 31), $urandom_range(0, 31),
             $urandom_range(0, 1), $urandom_range(0, 1));
    for (t = 0; t < n; t++) begin
      case ($urandom_range(0, 19))
        0:       push_req(MODE_DONE, t, $urandom_range(0, 31), 0, 0);
        1:       push_req(MODE_DONE, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 1), 0);
        default: push_req(MODE_DONE, t, $urandom_range(0, 31), 1, 0);
      endcase
    end
  endtask

  initial begin
    int span;
    int span_max;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Single slot, as left by reset: a one-task frame, a repeated completion
    // that is counted again, a self edge, and indexes beyond the slot range.
    push_req(MODE_START, 2, 0, 0, 0);
    push_req(MODE_DONE, 0, 0, 1, 0);
    push_req(MODE_DONE, 0, 31, 1, 0);
    push_req(MODE_EDGE, 0, 0, 0, 0);
    push_req(MODE_DONE, 31, 31, 1, 0);
    push_req(MODE_EDGE, 31, 30, 1, 0);

    // Full graph: accepted, duplicate and self edges, then a cycle through
    // tasks 0, 1 and 31 so those three are never dispatched. A failure ends
    // the counting, and a later success is then only taken off the open count.
    write_task_count(SLOTS);
    push_req(MODE_CLEAR, 31, 31, 1, 0);
    push_req(MODE_EDGE, 1, 0, 0, 0);
    push_req(MODE_EDGE, 1, 0, 1, 0);
    push_req(MODE_EDGE, 2, 2, 0, 0);
    push_req(MODE_EDGE, 31, 1, 0, 0);
    push_req(MODE_EDGE, 0, 31, 1, 0);
    push_req(MODE_START, 0, 0, 0, 1);
    push_req(MODE_DONE, 0, 0, 0, 0);
    push_req(MODE_DONE, 2, 0, 1, 0);

    // Shrink to two slots with the edges still in place: no roots, so the
    // frame completes at once; a spurious completion reports again, and the
    // next one frees task 1.
    write_task_count(2);
    push_req(MODE_START, 31, 0, 1, 0);
    push_req(MODE_DONE, 1, 0, 1, 0);
    push_req(MODE_DONE, 0, 0, 1, 0);

    // Empty full graph: every slot is a root, the largest burst of results.
    write_task_count(SLOTS);
    push_req(MODE_CLEAR, 0, 0, 0, 0);
    push_req(MODE_START, 0, 0, 0, 0);
    push_req(MODE_DONE, 5, 0, 1, 0);

    // Random frames across several slot counts, the extremes first. Later
    // frames are sized so that the run stays close to its request budget.
    write_task_count(1);
    build_frame(1, 1'b0);
    write_task_count(SLOTS);
    build_frame(SLOTS, 1'b1);
    while (reqs_queued < TOTAL_REQS) begin
      span_max = (TOTAL_REQS - reqs_queued - 2) / 3;
      if (span_max > SLOTS) span_max = SLOTS;
      if (span_max < 2) span_max = 2;
      span = $urandom_range(2, span_max);
      write_task_count(span);
      build_frame(span, 1'b0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dctd_pkg.sv
hw/rtl/dctd_ram.sv
hw/rtl/dctd_datapath.sv
hw/rtl/dctd_ctrl.sv
hw/rtl/dependency_counting_task_dispatcher_unit.sv
tb/testbench.sv
